// File: src/cascaded_biquad_lowpass_macros.svh
// ----------------------------------------------------------------------------
// Cascaded biquad low-pass: assertion macros
// Shared concurrent assertion wrappers, one clock and one active-low reset.
// ----------------------------------------------------------------------------
`ifndef CASCADED_BIQUAD_LOWPASS_MACROS_SVH
`define CASCADED_BIQUAD_LOWPASS_MACROS_SVH

// same-cycle implication
`define CBQ_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBQ_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cbq_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded biquad low-pass: package
// Widths, register map, microcode field codes, control/status types and
// the rounding/saturation helpers.
// ----------------------------------------------------------------------------
package cbq_pkg;

  // built section count
  localparam int MAX_SECTIONS = 8;
  localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  // field widths
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 26;
  localparam int HIST_W   = 32;
  localparam int SECT_W   = 4;
  localparam int PROD_W   = COEF_W + HIST_W;   // 58
  localparam int ACC_W    = PROD_W + 2;        // room for five products
  localparam int GPROD_W  = SAMPLE_W + COEF_W; // 50

  // APB register map
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_GAIN     = 3'd1;
  localparam logic [2:0] REG_FF0      = 3'd2;
  localparam logic [2:0] REG_FF1      = 3'd3;
  localparam logic [2:0] REG_FF2      = 3'd4;
  localparam logic [2:0] REG_FB1      = 3'd5;
  localparam logic [2:0] REG_FB2      = 3'd6;
  localparam logic [2:0] REG_SECTIONS = 3'd7;
  localparam logic signed [COEF_W-1:0] GAIN_RST = 26'sd4194304;
  localparam logic [SECT_W-1:0]        SECT_RST = 4'd4;

  // microcode steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] ST_GMUL = 4'd1;
  localparam logic [STEP_W-1:0] ST_GACC = 4'd2;
  localparam logic [STEP_W-1:0] ST_GSAT = 4'd3;
  localparam logic [STEP_W-1:0] ST_M0   = 4'd4;
  localparam logic [STEP_W-1:0] ST_M1   = 4'd5;
  localparam logic [STEP_W-1:0] ST_M2   = 4'd6;
  localparam logic [STEP_W-1:0] ST_M3   = 4'd7;
  localparam logic [STEP_W-1:0] ST_M4   = 4'd8;
  localparam logic [STEP_W-1:0] ST_A4   = 4'd9;
  localparam logic [STEP_W-1:0] ST_SSAT = 4'd10;
  localparam logic [STEP_W-1:0] ST_OUT  = 4'd11;
  localparam logic [STEP_W-1:0] ST_BYP  = 4'd12;

  // coefficient operand select
  localparam logic [2:0] MA_GAIN = 3'd0;
  localparam logic [2:0] MA_FF0  = 3'd1;
  localparam logic [2:0] MA_FF1  = 3'd2;
  localparam logic [2:0] MA_FF2  = 3'd3;
  localparam logic [2:0] MA_FB1  = 3'd4;
  localparam logic [2:0] MA_FB2  = 3'd5;

  // data operand select
  localparam logic [2:0] MB_SAMPLE = 3'd0;
  localparam logic [2:0] MB_X      = 3'd1;
  localparam logic [2:0] MB_PI1    = 3'd2;
  localparam logic [2:0] MB_PI2    = 3'd3;
  localparam logic [2:0] MB_PO1    = 3'd4;
  localparam logic [2:0] MB_PO2    = 3'd5;

  // accumulator ops
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  // working-sample ops
  localparam logic [1:0] XOP_NONE = 2'd0;
  localparam logic [1:0] XOP_GAIN = 2'd1;
  localparam logic [1:0] XOP_SECT = 2'd2;

  // output register ops
  localparam logic [1:0] OUT_NONE = 2'd0;
  localparam logic [1:0] OUT_FILT = 2'd1;
  localparam logic [1:0] OUT_BYP  = 2'd2;

  // stall conditions
  localparam logic [1:0] WAIT_NONE = 2'd0;
  localparam logic [1:0] WAIT_IN   = 2'd1;
  localparam logic [1:0] WAIT_OUT  = 2'd2;

  // jump conditions
  localparam logic [1:0] JMP_NONE   = 2'd0;
  localparam logic [1:0] JMP_ALWAYS = 2'd1;
  localparam logic [1:0] JMP_BYPASS = 2'd2;
  localparam logic [1:0] JMP_MORE   = 2'd3;

  // one microcode word
  typedef struct packed {
    logic [2:0]        ma;
    logic [2:0]        mb;
    logic [1:0]        acc_op;
    logic [1:0]        x_op;
    logic [1:0]        out_op;
    logic [1:0]        wait_c;
    logic [1:0]        jmp_c;
    logic [STEP_W-1:0] target;
  } uword_t;

  // control toward the datapath
  typedef struct packed {
    uword_t uw;
    logic   adv;   // step completes this cycle
  } ctl_t;

  // status back to the sequencer
  typedef struct packed {
    logic bypass;
    logic more;
    logic out_busy;
  } stat_t;

  // configuration registers
  typedef struct packed {
    logic                      enable;
    logic signed [COEF_W-1:0]  gain;
    logic signed [COEF_W-1:0]  ff0;
    logic signed [COEF_W-1:0]  ff1;
    logic signed [COEF_W-1:0]  ff2;
    logic signed [COEF_W-1:0]  fb1;
    logic signed [COEF_W-1:0]  fb2;
    logic [SECT_W-1:0]         sections;
  } cfg_t;

  // gained input: round off 17 bits, saturate to 32
  function automatic logic signed [HIST_W-1:0] rsat_gain(
      input logic signed [GPROD_W-1:0] v);
    logic signed [GPROD_W:0]  t;
    logic signed [GPROD_W-17:0] s;
    t = (GPROD_W+1)'(v) + (GPROD_W+1)'(65536);
    s = t[GPROD_W:17];
    if (s[GPROD_W-17:HIST_W-1] != {(GPROD_W-HIST_W-15){s[HIST_W-1]}}) begin
      rsat_gain = s[GPROD_W-17] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
    end else begin
      rsat_gain = s[HIST_W-1:0];
    end
  endfunction

  // section sum: round off 22 bits, saturate to 32
  function automatic logic signed [HIST_W-1:0] rsat_sect(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W:0]    t;
    logic signed [ACC_W-22:0] s;
    t = (ACC_W+1)'(v) + (ACC_W+1)'(2097152);
    s = t[ACC_W:22];
    if (s[ACC_W-22:HIST_W-1] != {(ACC_W-HIST_W-20){s[HIST_W-1]}}) begin
      rsat_sect = s[ACC_W-22] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
    end else begin
      rsat_sect = s[HIST_W-1:0];
    end
  endfunction

  // Q4.28 to Q1.23: round off 5 bits, saturate to 24
  function automatic logic signed [SAMPLE_W-1:0] rsat_out(
      input logic signed [HIST_W-1:0] v);
    logic signed [HIST_W:0]  t;
    logic signed [HIST_W-5:0] s;
    t = (HIST_W+1)'(v) + (HIST_W+1)'(16);
    s = t[HIST_W:5];
    if (s[HIST_W-5:SAMPLE_W-1] != {(HIST_W-SAMPLE_W-3){s[SAMPLE_W-1]}}) begin
      rsat_out = s[HIST_W-5] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      rsat_out = s[SAMPLE_W-1:0];
    end
  endfunction

endpackage

// File: src/cbq_regs.sv
// ----------------------------------------------------------------------------
// Cascaded biquad low-pass: configuration registers
// APB-style register file; every write also pulses a history clear.
// ----------------------------------------------------------------------------
module cbq_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbq_pkg::PADDR_W-1:0]   paddr,
  input  logic [cbq_pkg::PDATA_W-1:0]   pwdata,
  output logic [cbq_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output cbq_pkg::cfg_t                 cfg,
  output logic                          hist_clr
);

  cbq_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite;
  assign idx      = paddr[cbq_pkg::PADDR_W-1:2];
  assign hist_clr = wr_en;
  assign cfg      = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable   <= 1'b0;
      cfg_r.gain     <= cbq_pkg::GAIN_RST;
      cfg_r.ff0      <= '0;
      cfg_r.ff1      <= '0;
      cfg_r.ff2      <= '0;
      cfg_r.fb1      <= '0;
      cfg_r.fb2      <= '0;
      cfg_r.sections <= cbq_pkg::SECT_RST;
    end else if (wr_en) begin
      case (idx)
        cbq_pkg::REG_ENABLE:   cfg_r.enable   <= pwdata[0];
        cbq_pkg::REG_GAIN:     cfg_r.gain     <= pwdata[cbq_pkg::COEF_W-1:0];
        cbq_pkg::REG_FF0:      cfg_r.ff0      <= pwdata[cbq_pkg::COEF_W-1:0];
        cbq_pkg::REG_FF1:      cfg_r.ff1      <= pwdata[cbq_pkg::COEF_W-1:0];
        cbq_pkg::REG_FF2:      cfg_r.ff2      <= pwdata[cbq_pkg::COEF_W-1:0];
        cbq_pkg::REG_FB1:      cfg_r.fb1      <= pwdata[cbq_pkg::COEF_W-1:0];
        cbq_pkg::REG_FB2:      cfg_r.fb2      <= pwdata[cbq_pkg::COEF_W-1:0];
        cbq_pkg::REG_SECTIONS: cfg_r.sections <= pwdata[cbq_pkg::SECT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      cbq_pkg::REG_ENABLE:   prdata = cbq_pkg::PDATA_W'(cfg_r.enable);
      cbq_pkg::REG_GAIN:     prdata = cbq_pkg::PDATA_W'($unsigned(cfg_r.gain));
      cbq_pkg::REG_FF0:      prdata = cbq_pkg::PDATA_W'($unsigned(cfg_r.ff0));
      cbq_pkg::REG_FF1:      prdata = cbq_pkg::PDATA_W'($unsigned(cfg_r.ff1));
      cbq_pkg::REG_FF2:      prdata = cbq_pkg::PDATA_W'($unsigned(cfg_r.ff2));
      cbq_pkg::REG_FB1:      prdata = cbq_pkg::PDATA_W'($unsigned(cfg_r.fb1));
      cbq_pkg::REG_FB2:      prdata = cbq_pkg::PDATA_W'($unsigned(cfg_r.fb2));
      cbq_pkg::REG_SECTIONS: prdata = cbq_pkg::PDATA_W'(cfg_r.sections);
      default:               prdata = '0;
    endcase
  end

endmodule

// File: src/cbq_seq.sv
// ----------------------------------------------------------------------------
// Cascaded biquad low-pass: microcode sequencer
// Step counter over a read-only program; stalls on the handshakes and
// takes conditional jumps on datapath status.
// ----------------------------------------------------------------------------
`include "cascaded_biquad_lowpass_macros.svh"

module cbq_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cbq_pkg::stat_t stat,
  output cbq_pkg::ctl_t  ctl
);

  logic [cbq_pkg::STEP_W-1:0] step_r;
  logic [cbq_pkg::STEP_W-1:0] step_nxt;
  cbq_pkg::uword_t            uw;
  logic                       stall;
  logic                       jump;

  // program store
  function automatic cbq_pkg::uword_t rom(input logic [cbq_pkg::STEP_W-1:0] s);
    cbq_pkg::uword_t w;
    w.ma     = cbq_pkg::MA_GAIN;
    w.mb     = cbq_pkg::MB_SAMPLE;
    w.acc_op = cbq_pkg::ACC_NONE;
    w.x_op   = cbq_pkg::XOP_NONE;
    w.out_op = cbq_pkg::OUT_NONE;
    w.wait_c = cbq_pkg::WAIT_NONE;
    w.jmp_c  = cbq_pkg::JMP_NONE;
    w.target = cbq_pkg::ST_IDLE;
    case (s)
      cbq_pkg::ST_IDLE: w.wait_c = cbq_pkg::WAIT_IN;
      cbq_pkg::ST_GMUL: begin
        w.jmp_c  = cbq_pkg::JMP_BYPASS;
        w.target = cbq_pkg::ST_BYP;
      end
      cbq_pkg::ST_GACC: w.acc_op = cbq_pkg::ACC_LOAD;
      cbq_pkg::ST_GSAT: w.x_op   = cbq_pkg::XOP_GAIN;
      cbq_pkg::ST_M0: begin
        w.ma = cbq_pkg::MA_FF0;
        w.mb = cbq_pkg::MB_X;
      end
      cbq_pkg::ST_M1: begin
        w.ma     = cbq_pkg::MA_FF1;
        w.mb     = cbq_pkg::MB_PI1;
        w.acc_op = cbq_pkg::ACC_LOAD;
      end
      cbq_pkg::ST_M2: begin
        w.ma     = cbq_pkg::MA_FF2;
        w.mb     = cbq_pkg::MB_PI2;
        w.acc_op = cbq_pkg::ACC_ADD;
      end
      cbq_pkg::ST_M3: begin
        w.ma     = cbq_pkg::MA_FB1;
        w.mb     = cbq_pkg::MB_PO1;
        w.acc_op = cbq_pkg::ACC_ADD;
      end
      cbq_pkg::ST_M4: begin
        w.ma     = cbq_pkg::MA_FB2;
        w.mb     = cbq_pkg::MB_PO2;
        w.acc_op = cbq_pkg::ACC_ADD;
      end
      cbq_pkg::ST_A4: w.acc_op = cbq_pkg::ACC_ADD;
      cbq_pkg::ST_SSAT: begin
        w.x_op   = cbq_pkg::XOP_SECT;
        w.jmp_c  = cbq_pkg::JMP_MORE;
        w.target = cbq_pkg::ST_M0;
      end
      cbq_pkg::ST_OUT: begin
        w.out_op = cbq_pkg::OUT_FILT;
        w.wait_c = cbq_pkg::WAIT_OUT;
        w.jmp_c  = cbq_pkg::JMP_ALWAYS;
      end
      cbq_pkg::ST_BYP: begin
        w.out_op = cbq_pkg::OUT_BYP;
        w.wait_c = cbq_pkg::WAIT_OUT;
        w.jmp_c  = cbq_pkg::JMP_ALWAYS;
      end
      default: w.jmp_c = cbq_pkg::JMP_ALWAYS;
    endcase
    return w;
  endfunction

  assign uw = rom(step_r);

  // stall and jump decode
  always_comb begin
    case (uw.wait_c)
      cbq_pkg::WAIT_IN:  stall = !in_valid;
      cbq_pkg::WAIT_OUT: stall = stat.out_busy;
      default:           stall = 1'b0;
    endcase
    case (uw.jmp_c)
      cbq_pkg::JMP_ALWAYS: jump = 1'b1;
      cbq_pkg::JMP_BYPASS: jump = stat.bypass;
      cbq_pkg::JMP_MORE:   jump = stat.more;
      default:             jump = 1'b0;
    endcase
    if (stall) begin
      step_nxt = step_r;
    end else if (jump) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= cbq_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign in_ready = (uw.wait_c == cbq_pkg::WAIT_IN);
  assign ctl.uw   = uw;
  assign ctl.adv  = !stall;

  // checks
  `CBQ_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && in_ready, step_r == cbq_pkg::ST_GMUL, "accept did not start the program")
  `CBQ_ASSERT_IMP(a_step_range, clk, rst_n, 1'b1, step_r <= cbq_pkg::ST_BYP, "step outside program")

endmodule

// File: src/cbq_dpath.sv
// ----------------------------------------------------------------------------
// Cascaded biquad low-pass: datapath
// One shared multiplier with registered product, accumulator, working
// sample, per-section history and the output register.
// ----------------------------------------------------------------------------
`include "cascaded_biquad_lowpass_macros.svh"

module cbq_dpath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cbq_pkg::ctl_t                         ctl,
  input  cbq_pkg::cfg_t                         cfg,
  input  logic                                  hist_clr,
  input  logic signed [cbq_pkg::SAMPLE_W-1:0]   in_sample_in,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [cbq_pkg::SAMPLE_W-1:0]   out_sample_out,
  output cbq_pkg::stat_t                        stat
);

  localparam int NS = cbq_pkg::MAX_SECTIONS;

  logic signed [cbq_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [cbq_pkg::HIST_W-1:0]   x_r;
  logic signed [cbq_pkg::PROD_W-1:0]   p_r;
  logic signed [cbq_pkg::PROD_W-1:0]   p_nxt;
  logic signed [cbq_pkg::ACC_W-1:0]    acc_r;
  logic [cbq_pkg::SEC_W-1:0]           sec_r;
  logic signed [cbq_pkg::HIST_W-1:0]   pi1_r [NS];
  logic signed [cbq_pkg::HIST_W-1:0]   pi2_r [NS];
  logic signed [cbq_pkg::HIST_W-1:0]   po1_r [NS];
  logic signed [cbq_pkg::HIST_W-1:0]   po2_r [NS];
  logic                                out_valid_r;
  logic signed [cbq_pkg::SAMPLE_W-1:0] out_r;
  logic signed [cbq_pkg::COEF_W-1:0]   op_a;
  logic signed [cbq_pkg::HIST_W-1:0]   op_b;
  logic signed [cbq_pkg::HIST_W-1:0]   sect_y;
  logic [7:0]                          sect_w;
  logic [7:0]                          eff_cnt;
  logic                                in_take;
  logic                                sect_wr;
  logic                                out_wr;

  assign in_take = ctl.adv && (ctl.uw.wait_c == cbq_pkg::WAIT_IN);
  assign sect_wr = ctl.adv && (ctl.uw.x_op == cbq_pkg::XOP_SECT);
  assign out_wr  = ctl.adv && (ctl.uw.out_op != cbq_pkg::OUT_NONE);

  // clamp section count to 1..MAX_SECTIONS
  always_comb begin
    sect_w = 8'(cfg.sections);
    if (sect_w == 8'd0) begin
      eff_cnt = 8'd1;
    end else if (sect_w > 8'(NS)) begin
      eff_cnt = 8'(NS);
    end else begin
      eff_cnt = sect_w;
    end
  end

  // operand selects
  always_comb begin
    case (ctl.uw.ma)
      cbq_pkg::MA_GAIN: op_a = cfg.gain;
      cbq_pkg::MA_FF0:  op_a = cfg.ff0;
      cbq_pkg::MA_FF1:  op_a = cfg.ff1;
      cbq_pkg::MA_FF2:  op_a = cfg.ff2;
      cbq_pkg::MA_FB1:  op_a = cfg.fb1;
      cbq_pkg::MA_FB2:  op_a = cfg.fb2;
      default:          op_a = '0;
    endcase
    case (ctl.uw.mb)
      cbq_pkg::MB_SAMPLE: op_b = cbq_pkg::HIST_W'(sample_r);
      cbq_pkg::MB_X:      op_b = x_r;
      cbq_pkg::MB_PI1:    op_b = pi1_r[sec_r];
      cbq_pkg::MB_PI2:    op_b = pi2_r[sec_r];
      cbq_pkg::MB_PO1:    op_b = po1_r[sec_r];
      cbq_pkg::MB_PO2:    op_b = po2_r[sec_r];
      default:            op_b = '0;
    endcase
  end

  assign p_nxt  = cbq_pkg::PROD_W'(op_a) * cbq_pkg::PROD_W'(op_b);
  assign sect_y = cbq_pkg::rsat_sect(acc_r);

  // multiply, accumulate, working sample
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (in_take) begin
      sample_r <= in_sample_in;
    end
    if (ctl.adv) begin
      case (ctl.uw.acc_op)
        cbq_pkg::ACC_LOAD: acc_r <= cbq_pkg::ACC_W'(p_r);
        cbq_pkg::ACC_ADD:  acc_r <= acc_r + cbq_pkg::ACC_W'(p_r);
        default: ;
      endcase
      case (ctl.uw.x_op)
        cbq_pkg::XOP_GAIN: x_r <= cbq_pkg::rsat_gain(acc_r[cbq_pkg::GPROD_W-1:0]);
        cbq_pkg::XOP_SECT: x_r <= sect_y;
        default: ;
      endcase
    end
  end

  // section index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r <= '0;
    end else if (ctl.adv && ctl.uw.x_op == cbq_pkg::XOP_GAIN) begin
      sec_r <= '0;
    end else if (sect_wr) begin
      sec_r <= sec_r + 1'b1;
    end
  end

  // section history
  always_ff @(posedge clk) begin
    if (!rst_n || hist_clr) begin
      for (int i = 0; i < NS; i++) begin
        pi1_r[i] <= '0;
        pi2_r[i] <= '0;
        po1_r[i] <= '0;
        po2_r[i] <= '0;
      end
    end else if (sect_wr) begin
      pi2_r[sec_r] <= pi1_r[sec_r];
      pi1_r[sec_r] <= x_r;
      po2_r[sec_r] <= po1_r[sec_r];
      po1_r[sec_r] <= sect_y;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) begin
      out_r <= (ctl.uw.out_op == cbq_pkg::OUT_BYP) ? sample_r : cbq_pkg::rsat_out(x_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;
  assign stat.bypass    = !cfg.enable;
  assign stat.more      = (8'(sec_r) + 8'd1) < eff_cnt;
  assign stat.out_busy  = out_valid_r && !out_ready;

  // checks
  `CBQ_ASSERT_IMP(a_out_slot_free, clk, rst_n, out_wr, !out_valid_r || out_ready, "output word overwritten")
  `CBQ_ASSERT_IMP(a_sect_in_range, clk, rst_n, sect_wr, 8'(sec_r) < eff_cnt, "section index past active count")
  `CBQ_ASSERT_NXT(a_hist_cleared, clk, rst_n, hist_clr, po1_r[0] == '0 && pi1_r[0] == '0, "history not cleared")

endmodule

// File: src/cascaded_biquad_lowpass.sv
// One word is processed at a time; a new word is taken only once the last one has reached
// the output register. Each section runs five products on the single shared multiplier,
//   plus two further steps.
// A finished word waits in the output register while the next word is taken in.
// Reset (rst_n, synchronous, low): history cleared, gain 1.0, four sections, bypass.
// ----------------------------------------------------------------------------
// Cascaded biquad low-pass: top level
// Microcoded direct-form-1 biquad cascade with APB configuration.
// ----------------------------------------------------------------------------
module cascaded_biquad_lowpass (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cbq_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cbq_pkg::SAMPLE_W-1:0]  out_sample_out,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cbq_pkg::PADDR_W-1:0]          paddr,
  input  logic [cbq_pkg::PDATA_W-1:0]          pwdata,
  output logic [cbq_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);

  cbq_pkg::cfg_t  cfg;
  cbq_pkg::ctl_t  ctl;
  cbq_pkg::stat_t stat;
  logic           hist_clr;

  cbq_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .hist_clr (hist_clr)
  );

  cbq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  cbq_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .cfg            (cfg),
    .hist_clr       (hist_clr),
    .in_sample_in   (in_sample_in),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_sample_out (out_sample_out),
    .stat           (stat)
  );

endmodule

// File: test/cascaded_biquad_lowpass_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cascaded biquad low-pass: testbench
// Streams Q1.23 words through the filter under random idling on both sides,
// predicts every output word from a fixed-point model of the section cascade
// kept in a scoreboard, and reloads the coefficient set between phases
// (bypass, unity, saturating extremes, stable low-pass and random sets).
// ----------------------------------------------------------------------------

// Expected-word store plus fixed-point model of gain, cascade and output rounding
class biquad_scoreboard;
  bit                                   enable;
  logic signed [cbq_pkg::COEF_W-1:0]    gain, ff0, ff1, ff2, fb1, fb2;
  logic [cbq_pkg::SECT_W-1:0]           sections;
  int                                   hist_x1[cbq_pkg::MAX_SECTIONS];
  int                                   hist_x2[cbq_pkg::MAX_SECTIONS];
  int                                   hist_y1[cbq_pkg::MAX_SECTIONS];
  int                                   hist_y2[cbq_pkg::MAX_SECTIONS];
  logic signed [cbq_pkg::SAMPLE_W-1:0]  expected_q[$];
  int                                   words_in;
  int                                   words_checked;
  int                                   mismatches;

  function new();
    enable   = 1'b0;
    gain     = cbq_pkg::GAIN_RST;
    ff0      = '0;
    ff1      = '0;
    ff2      = '0;
    fb1      = '0;
    fb2      = '0;
    sections = cbq_pkg::SECT_RST;
    words_in = 0;
    words_checked = 0;
    mismatches = 0;
    clear_history();
  endfunction

  function void clear_history();
    for (int n = 0; n < cbq_pkg::MAX_SECTIONS; n++) begin
      hist_x1[n] = 0;
      hist_x2[n] = 0;
      hist_y1[n] = 0;
      hist_y2[n] = 0;
    end
  endfunction

  // any register write also flushes every section's history
  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      cbq_pkg::REG_ENABLE:   enable = data[0];
      cbq_pkg::REG_GAIN:     gain = data[cbq_pkg::COEF_W-1:0];
      cbq_pkg::REG_FF0:      ff0 = data[cbq_pkg::COEF_W-1:0];
      cbq_pkg::REG_FF1:      ff1 = data[cbq_pkg::COEF_W-1:0];
      cbq_pkg::REG_FF2:      ff2 = data[cbq_pkg::COEF_W-1:0];
      cbq_pkg::REG_FB1:      fb1 = data[cbq_pkg::COEF_W-1:0];
      cbq_pkg::REG_FB2:      fb2 = data[cbq_pkg::COEF_W-1:0];
      cbq_pkg::REG_SECTIONS: sections = data[cbq_pkg::SECT_W-1:0];
      default: ;
    endcase
    clear_history();
  endfunction

  // round half up while dropping s bits
  function longint rnd_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function logic signed [cbq_pkg::SAMPLE_W-1:0] filter_word(
      logic signed [cbq_pkg::SAMPLE_W-1:0] s);
    longint x;
    longint acc;
    int     count;
    if (!enable) return s;
    // Q1.23 * Q4.22 -> Q4.28
    x = clamp(rnd_shr(longint'(s) * longint'(gain), 17), 32);
    count = int'(sections);
    if (count < 1) count = 1;
    if (count > cbq_pkg::MAX_SECTIONS) count = cbq_pkg::MAX_SECTIONS;
    for (int n = 0; n < count; n++) begin
      acc = longint'(ff0) * x
          + longint'(ff1) * longint'(hist_x1[n])
          + longint'(ff2) * longint'(hist_x2[n])
          + longint'(fb1) * longint'(hist_y1[n])
          + longint'(fb2) * longint'(hist_y2[n]);
      acc = clamp(rnd_shr(acc, 22), 32);
      hist_y2[n] = hist_y1[n];
      hist_y1[n] = int'(acc);
      hist_x2[n] = hist_x1[n];
      hist_x1[n] = int'(x);
      x = acc;
    end
    // Q4.28 -> Q1.23
    x = clamp(rnd_shr(x, 5), 24);
    return x[cbq_pkg::SAMPLE_W-1:0];
  endfunction

  function void note_word(logic signed [cbq_pkg::SAMPLE_W-1:0] s);
    expected_q.push_back(filter_word(s));
    words_in++;
  endfunction

  function void check_word(logic signed [cbq_pkg::SAMPLE_W-1:0] actual);
    logic signed [cbq_pkg::SAMPLE_W-1:0] want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: output word %0d with nothing pending", $realtime, actual);
      return;
    end
    want = expected_q.pop_front();
    words_checked++;
    if (actual !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: word %0d sample_out expected %0d, got %0d",
                 $realtime, words_checked, want, actual);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module cascaded_biquad_lowpass_tb;

  localparam int ONE_Q22  = 4194304;
  localparam int COEF_MAX = 33554431;
  localparam int COEF_MIN = -33554432;
  localparam int SMP_MAX  = 8388607;
  localparam int SMP_MIN  = -8388608;

  // coefficient set styles for the random phases
  localparam int CFG_LOWPASS = 0;
  localparam int CFG_WILD    = 1;
  localparam int CFG_BYPASS  = 2;
  localparam int CFG_GENTLE  = 3;

  // input word patterns
  localparam int PAT_NOISE = 0;
  localparam int PAT_STEPS = 1;
  localparam int PAT_EDGES = 2;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic signed [cbq_pkg::SAMPLE_W-1:0]  in_sample_in;
  logic                                 out_valid;
  logic                                 out_ready;
  logic signed [cbq_pkg::SAMPLE_W-1:0]  out_sample_out;
  logic                                 psel;
  logic                                 penable;
  logic                                 pwrite;
  logic [cbq_pkg::PADDR_W-1:0]          paddr;
  logic [cbq_pkg::PDATA_W-1:0]          pwdata;
  logic [cbq_pkg::PDATA_W-1:0]          prdata;
  logic                                 pready;

  biquad_scoreboard sb;
  bit               steady;       // no idling on either side this phase
  int               settings_used;

  cascaded_biquad_lowpass uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog for the slowest run of roughly 550 words, each with its gap, busy and stall
  // time; the 5 ms limit leaves a wide margin.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // one input word, with a random hold-off first
  task automatic send_word(logic signed [cbq_pkg::SAMPLE_W-1:0] s);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_word(s);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic apb_write(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cbq_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(int en, int g, int c0, int c1, int c2,
                             int d1, int d2, int sect);
    apb_write(cbq_pkg::REG_ENABLE, en);
    apb_write(cbq_pkg::REG_GAIN, g);
    apb_write(cbq_pkg::REG_FF0, c0);
    apb_write(cbq_pkg::REG_FF1, c1);
    apb_write(cbq_pkg::REG_FF2, c2);
    apb_write(cbq_pkg::REG_FB1, d1);
    apb_write(cbq_pkg::REG_FB2, d2);
    apb_write(cbq_pkg::REG_SECTIONS, sect);
    settings_used++;
    steady = ($urandom_range(0, 3) == 0);
  endtask

  // let every pending word drain, then allow for a full filtered pass
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  function automatic logic signed [cbq_pkg::SAMPLE_W-1:0] next_word(
      int pat, logic signed [cbq_pkg::SAMPLE_W-1:0] prev);
    case (pat)
      PAT_STEPS: return ($urandom_range(0, 9) == 0) ? cbq_pkg::SAMPLE_W'($urandom) : prev;
      PAT_EDGES: begin
        case ($urandom_range(0, 3))
          0:       return cbq_pkg::SAMPLE_W'(SMP_MIN);
          1:       return cbq_pkg::SAMPLE_W'(SMP_MAX);
          default: return cbq_pkg::SAMPLE_W'($urandom);
        endcase
      end
      default: return cbq_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // result side: random stall before each word, check on accept
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_word(out_sample_out);
    end
  end

  initial begin
    int                                   c0;
    int                                   sect;
    int                                   pat;
    logic signed [cbq_pkg::SAMPLE_W-1:0]  smp;

    sb            = new();
    steady        = 1'b0;
    settings_used = 1;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_sample_in <= '0;
    out_ready    <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: bypass, words pass unchanged
    send_word(cbq_pkg::SAMPLE_W'(SMP_MIN));
    send_word(cbq_pkg::SAMPLE_W'(SMP_MAX));
    send_word('0);
    send_word(cbq_pkg::SAMPLE_W'(-1));
    send_word(cbq_pkg::SAMPLE_W'(1));
    wait_idle();

    // unity gain and a single unity tap in every section
    load_config(1, ONE_Q22, ONE_Q22, 0, 0, 0, 0, 4);
    send_word(cbq_pkg::SAMPLE_W'(SMP_MIN));
    send_word(cbq_pkg::SAMPLE_W'(SMP_MAX));
    send_word(24'sh555555);
    send_word(24'shAAAAAA);
    send_word(cbq_pkg::SAMPLE_W'(-1));
    wait_idle();

    // gain saturation; section count zero acts as one
    load_config(1, COEF_MIN, COEF_MAX, 0, 0, COEF_MIN, 0, 0);
    send_word(cbq_pkg::SAMPLE_W'(SMP_MIN));
    send_word(cbq_pkg::SAMPLE_W'(SMP_MAX));
    send_word(cbq_pkg::SAMPLE_W'(1));
    wait_idle();

    // stable low-pass, count above the built sections clips to eight; step input
    load_config(1, ONE_Q22, 83886, 167772, 83886, 6291456, -2684355, 15);
    repeat (6) send_word(cbq_pkg::SAMPLE_W'(SMP_MAX));
    wait_idle();

    // all coefficients at full scale: every section saturates
    load_config(1, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 8);
    send_word(cbq_pkg::SAMPLE_W'(SMP_MIN));
    send_word(cbq_pkg::SAMPLE_W'(SMP_MAX));
    send_word(cbq_pkg::SAMPLE_W'(SMP_MIN));
    send_word(cbq_pkg::SAMPLE_W'(SMP_MAX));
    wait_idle();

    // random phases, each coefficient style in turn
    for (int p = 0; p < 12; p++) begin
      sect = $urandom_range(0, 15);
      case (p % 4)
        CFG_LOWPASS: begin
          c0 = $urandom_range(20000, 150000);
          load_config(1, ONE_Q22 + $urandom_range(0, 2097152) - 1048576,
                      c0, 2 * c0, c0, $urandom_range(5000000, 6500000),
                      -int'($urandom_range(2500000, 3500000)), sect);
        end
        CFG_WILD: begin
          load_config(int'($urandom | 32'd1), $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        end
        CFG_BYPASS: begin
          load_config(int'($urandom & ~32'd1), $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, sect);
        end
        default: begin
          load_config(1, $urandom_range(0, 8388608) - 4194304,
                      $urandom_range(0, 4194304) - 2097152,
                      $urandom_range(0, 4194304) - 2097152,
                      $urandom_range(0, 4194304) - 2097152,
                      $urandom_range(0, 4194304) - 2097152,
                      $urandom_range(0, 4194304) - 2097152, sect);
        end
      endcase
      pat = $urandom_range(PAT_NOISE, PAT_EDGES);
      smp = cbq_pkg::SAMPLE_W'($urandom);
      for (int k = 0; k < 42; k++) begin
        smp = next_word(pat, smp);
        send_word(smp);
      end
      wait_idle();
    end

    $display("Covered %0d words over %0d register settings: bypass, unity,",
             sb.words_in, settings_used);
    $display("saturating and random coefficient sets, 1 to 8 sections; %0d checked.",
             sb.words_checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d words still pending", sb.mismatches, sb.pending());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
